[src/assert_macros.svh]
// assertion macros used by the controller core
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define WFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/wfc_pkg.sv]
// types and constants for the waypoint follow controller
// no dependencies
package wfc_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_ABORT  = 2'd3
  } op_t;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_RUNNING   = 3'd1;
  localparam logic [2:0] ST_COMPLETED = 3'd2;
  localparam logic [2:0] ST_CANCELED  = 3'd3;
  localparam logic [2:0] ST_ABORTED   = 3'd4;
  localparam logic [2:0] ST_REJECTED  = 3'd5;

  localparam logic [1:0] CFG_SPEED_GAIN = 2'd0;
  localparam logic [1:0] CFG_TURN_GAIN  = 2'd1;
  localparam logic [1:0] CFG_ARRIVE_TOL = 2'd2;

  localparam logic signed [17:0] Q_PI      = 18'sd25736;
  localparam logic signed [17:0] Q_TWO_PI  = 18'sd51472;
  localparam logic signed [16:0] Q_HALF_PI = 17'sd12868;
  localparam logic [12:0] LIN_CAP = 13'd4096;
  localparam logic signed [15:0] ANG_CAP = 16'sd16384;
  localparam logic [3:0] CORDIC_LAST = 4'd13;

  typedef struct packed {
    logic [1:0]          op;
    logic signed [15:0]  pose_x;
    logic signed [15:0]  pose_y;
    logic signed [15:0]  pose_theta;
  } in_t;

  typedef struct packed {
    logic [12:0]         cmd_linear;
    logic signed [15:0]  cmd_angular;
    logic [1:0]          waypoint_number;
    logic [15:0]         distance;
    logic [2:0]          status;
  } out_t;

  // rounded atan(2^-i) in Q3.13
  function automatic logic [12:0] atan_q13(input logic [3:0] i);
    case (i)
      4'd0:    atan_q13 = 13'd6434;
      4'd1:    atan_q13 = 13'd3798;
      4'd2:    atan_q13 = 13'd2007;
      4'd3:    atan_q13 = 13'd1019;
      4'd4:    atan_q13 = 13'd511;
      4'd5:    atan_q13 = 13'd256;
      4'd6:    atan_q13 = 13'd128;
      4'd7:    atan_q13 = 13'd64;
      4'd8:    atan_q13 = 13'd32;
      4'd9:    atan_q13 = 13'd16;
      4'd10:   atan_q13 = 13'd8;
      4'd11:   atan_q13 = 13'd4;
      4'd12:   atan_q13 = 13'd2;
      4'd13:   atan_q13 = 13'd1;
      default: atan_q13 = 13'd0;
    endcase
  endfunction

  // waypoint table, Q5.11
  function automatic logic [15:0] wp_x(input logic [1:0] idx);
    case (idx)
      2'd0:    wp_x = 16'd4096;
      2'd1:    wp_x = 16'd18432;
      2'd2:    wp_x = 16'd18432;
      default: wp_x = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] wp_y(input logic [1:0] idx);
    case (idx)
      2'd0:    wp_y = 16'd4096;
      2'd1:    wp_y = 16'd4096;
      2'd2:    wp_y = 16'd18432;
      default: wp_y = 16'd0;
    endcase
  endfunction

endpackage

[src/waypoint_follow_controller_core.sv]
// waypoint follow controller, top level with sequencer and shared multiplier
// depends on wfc_pkg and assert_macros.svh
`include "assert_macros.svh"

// Start, cancel, abort, ticks while idle and ticks past the last waypoint
// go straight from the input transfer to the output step. Any other tick
// while running squares dx and dy in the multiplier (S_SQX, S_SQY), takes 17
// bit-serial square-root steps plus a check step, 14 CORDIC vectoring steps,
// then a multiplier step each for the linear and angular commands (S_LIN,
// S_ANG), and the move into the output register; an arrival ends after the
// square root. All products go through one shared 19x19 signed multiplier.
// The input is stalled until the result has been moved into the output
// register.
module waypoint_follow_controller_core #(
  parameter int NUM_WAYPOINTS = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  wfc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output wfc_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SQX  = 8'b0000_0010,
    S_SQY  = 8'b0000_0100,
    S_SQRT = 8'b0000_1000,
    S_CORD = 8'b0001_0000,
    S_LIN  = 8'b0010_0000,
    S_ANG  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state;
  logic [11:0] speed_gain;
  logic [11:0] turn_gain;
  logic [12:0] arrive_tolerance;
  logic        running;
  logic [1:0]  waypoint_index;
  logic        pose_seen;

  logic signed [17:0] dx, dy;
  logic signed [15:0] th;
  logic [33:0] sq, rem, root, bitm;
  logic signed [27:0] cx, cy;
  logic signed [16:0] cz;
  logic [3:0]  iter;
  logic        zero_vec;
  logic signed [17:0] err;
  wfc_pkg::out_t res;
  wfc_pkg::out_t first_res;

  logic signed [18:0] mul_a, mul_b;
  logic signed [37:0] prod;
  logic        in_fire;
  logic        past_end;
  logic [2:0]  wp_next;
  logic [33:0] trial;
  logic signed [27:0] xs, ys;
  logic signed [17:0] err_raw;
  logic signed [29:0] lin_full;
  logic signed [28:0] ang_full;
  logic [16:0] root_lo;
  logic signed [17:0] dx_in, dy_in;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;
  assign wp_next   = {1'b0, waypoint_index} + 3'd1;
  assign past_end  = ({1'b0, waypoint_index} >= 3'(NUM_WAYPOINTS))
                     || (waypoint_index > 2'd2);
  assign trial     = root + bitm;
  assign xs        = cx >>> iter;
  assign ys        = cy >>> iter;
  assign root_lo   = root[16:0];
  assign dx_in = $signed({2'b00, wfc_pkg::wp_x(waypoint_index)})
               - 18'(in_data.pose_x);
  assign dy_in = $signed({2'b00, wfc_pkg::wp_y(waypoint_index)})
               - 18'(in_data.pose_y);
  assign err_raw = (zero_vec ? 18'sd0 : 18'(cz)) - 18'(th);
  assign lin_full = 30'(prod >>> 8);
  assign ang_full = 29'(prod >>> 9);

  // result fields known at the input transfer
  always_comb begin
    first_res = '0;
    unique case (in_data.op) inside
      wfc_pkg::OP_START: begin
        if (!pose_seen) begin
          first_res.status = wfc_pkg::ST_REJECTED;
        end else begin
          first_res.waypoint_number = 2'd1;
          first_res.status          = wfc_pkg::ST_RUNNING;
        end
      end
      wfc_pkg::OP_CANCEL, wfc_pkg::OP_ABORT: begin
        if (running) begin
          first_res.status = (in_data.op == wfc_pkg::OP_CANCEL) ?
                             wfc_pkg::ST_CANCELED : wfc_pkg::ST_ABORTED;
        end
      end
      default: begin
        if (running) begin
          if (past_end) begin
            first_res.status = wfc_pkg::ST_COMPLETED;
          end else begin
            first_res.waypoint_number = wp_next[1:0];
            first_res.status          = wfc_pkg::ST_RUNNING;
          end
        end
      end
    endcase
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX: begin
        mul_a = 19'(dx);
        mul_b = 19'(dx);
      end
      S_SQY: begin
        mul_a = 19'(dy);
        mul_b = 19'(dy);
      end
      S_LIN: begin
        mul_a = $signed({7'd0, speed_gain});
        mul_b = $signed({1'b0, root[17:0]});
      end
      S_ANG: begin
        mul_a = $signed({7'd0, turn_gain});
        mul_b = 19'(err);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain       <= 12'd384;
      turn_gain        <= 12'd1536;
      arrive_tolerance <= 13'd307;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wfc_pkg::CFG_SPEED_GAIN: speed_gain       <= cfg_data[11:0];
        wfc_pkg::CFG_TURN_GAIN:  turn_gain        <= cfg_data[11:0];
        wfc_pkg::CFG_ARRIVE_TOL: arrive_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      running        <= 1'b0;
      waypoint_index <= '0;
      pose_seen      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res   <= first_res;
            state <= S_DONE;
            unique case (in_data.op) inside
              wfc_pkg::OP_START: begin
                if (pose_seen) begin
                  running        <= 1'b1;
                  waypoint_index <= '0;
                end
              end
              wfc_pkg::OP_CANCEL, wfc_pkg::OP_ABORT: begin
                if (running) begin
                  running        <= 1'b0;
                  waypoint_index <= '0;
                end
              end
              default: begin
                pose_seen <= 1'b1;
                if (running) begin
                  if (past_end) begin
                    running        <= 1'b0;
                    waypoint_index <= '0;
                  end else begin
                    dx    <= dx_in;
                    dy    <= dy_in;
                    th    <= in_data.pose_theta;
                    state <= S_SQX;
                  end
                end
              end
            endcase
          end
        end
        S_SQX: begin
          sq    <= prod[33:0];
          state <= S_SQY;
        end
        S_SQY: begin
          rem   <= sq + prod[33:0];
          root  <= '0;
          bitm  <= 34'd1 << 32;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (bitm != '0) begin
            if (rem >= trial) begin
              rem  <= rem - trial;
              root <= (root >> 1) + bitm;
            end else begin
              root <= root >> 1;
            end
            bitm <= bitm >> 2;
          end else begin
            res.distance <= root_lo[16] ? 16'hFFFF : root_lo[15:0];
            if (root_lo < 17'(arrive_tolerance)) begin
              // arrival: stop and move on to the next waypoint
              if (wp_next >= 3'(NUM_WAYPOINTS)) begin
                running        <= 1'b0;
                waypoint_index <= '0;
                res.status     <= wfc_pkg::ST_COMPLETED;
              end else begin
                waypoint_index <= wp_next[1:0];
              end
              state <= S_DONE;
            end else begin
              zero_vec <= (dx == '0) && (dy == '0);
              iter     <= '0;
              // pre-rotate left half plane by a quarter turn
              if (dx < 0) begin
                if (dy >= 0) begin
                  cx <= 28'(dy) <<< 8;
                  cy <= -(28'(dx) <<< 8);
                  cz <= wfc_pkg::Q_HALF_PI;
                end else begin
                  cx <= -(28'(dy) <<< 8);
                  cy <= 28'(dx) <<< 8;
                  cz <= -wfc_pkg::Q_HALF_PI;
                end
              end else begin
                cx <= 28'(dx) <<< 8;
                cy <= 28'(dy) <<< 8;
                cz <= '0;
              end
              state <= S_CORD;
            end
          end
        end
        S_CORD: begin
          if (cy >= 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + $signed({4'd0, wfc_pkg::atan_q13(iter)});
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - $signed({4'd0, wfc_pkg::atan_q13(iter)});
          end
          iter <= iter + 4'd1;
          if (iter == wfc_pkg::CORDIC_LAST) state <= S_LIN;
        end
        S_LIN: begin
          res.cmd_linear <= (lin_full > 30'sd4096) ? wfc_pkg::LIN_CAP
                                                   : lin_full[12:0];
          // heading error wrapped into plus or minus pi
          if (err_raw > wfc_pkg::Q_PI) err <= err_raw - wfc_pkg::Q_TWO_PI;
          else if (err_raw < -wfc_pkg::Q_PI) err <= err_raw + wfc_pkg::Q_TWO_PI;
          else err <= err_raw;
          state <= S_ANG;
        end
        S_ANG: begin
          if (ang_full > 29'(wfc_pkg::ANG_CAP))
            res.cmd_angular <= wfc_pkg::ANG_CAP;
          else if (ang_full < -29'(wfc_pkg::ANG_CAP))
            res.cmd_angular <= -wfc_pkg::ANG_CAP;
          else
            res.cmd_angular <= ang_full[15:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WFC_ASSERT(a_run_needs_pose, !running || pose_seen, "running without a pose")
  `WFC_ASSERT(a_idle_index, running || (waypoint_index == 2'd0), "stale index while idle")
  `WFC_ASSERT(a_lin_cap, !out_valid || (out_data.cmd_linear <= wfc_pkg::LIN_CAP), "linear over cap")
  `WFC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, state != S_IDLE, "no work after transfer")

endmodule
